FILE: sv/ctss_pkg.sv
// shared constants, types and helpers of the compare timer slot scheduler
`default_nettype none

package ctss_pkg;

  // slot storage
  localparam int SLOT_COUNT = 6;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int THR_W  = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd30;
  localparam logic REG_THRESHOLD = 1'b0;

  // no-deadline distance
  localparam logic [15:0] DIST_NONE = 16'hffff;

  // operation codes
  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_RESCAN   = 2'd1;
  localparam logic [1:0] OP_RELEASE  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_FIRED    = 2'd0;
  localparam logic [1:0] KIND_COMPARE  = 2'd1;
  localparam logic [1:0] KIND_RELEASED = 2'd2;
  localparam logic [1:0] KIND_NO_SLOT  = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;

  // write controls into the slot file
  typedef struct packed {
    logic        sched;
    idx_t        sched_idx;
    logic [15:0] deadline;
    logic [7:0]  tag;
    logic        rel;
    idx_t        rel_idx;
    logic        dis;
    idx_t        dis_idx;
  } slot_cmd_t;

  // one slot as read back
  typedef struct packed {
    logic        enabled;
    logic [15:0] deadline;
    logic [7:0]  tag;
  } slot_entry_t;

  // free slot lookup
  typedef struct packed {
    logic any_free;
    idx_t first_free;
  } free_info_t;

  // slot index to the 3-bit result field
  function automatic logic [2:0] slot_field(idx_t idx);
    logic [7:0] w;
    w = 8'(idx);
    return w[2:0];
  endfunction

  // 3-bit slot field to a slot index
  function automatic idx_t slot_index(logic [2:0] s);
    logic [7:0] w;
    w = 8'(s);
    return w[IDX_W-1:0];
  endfunction

  // slot field names an existing slot
  function automatic logic slot_in_range(logic [2:0] s);
    return 6'(s) < 6'(SLOT_COUNT);
  endfunction

endpackage

`default_nettype wire

FILE: sv/ctss_if.sv
// request and result channel interfaces of the slot scheduler
`default_nettype none

interface ctss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] now;
  logic [15:0] deadline;
  logic [7:0]  tag;
  logic [2:0]  slot;

  modport source (output valid, operation, now, deadline, tag, slot, input ready);
  modport sink (input valid, operation, now, deadline, tag, slot, output ready);
endinterface

interface ctss_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  result_slot;
  logic [7:0]  result_tag;
  logic [15:0] result_deadline;
  logic [15:0] compare_value;
  logic        last;

  modport source (output valid, kind, result_slot, result_tag, result_deadline,
                  compare_value, last, input ready);
  modport sink (input valid, kind, result_slot, result_tag, result_deadline,
                compare_value, last, output ready);
endinterface

`default_nettype wire

FILE: sv/ctss_apb_regs.sv
// configuration register block holding the due threshold
`default_nettype none

module ctss_apb_regs
  import ctss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [THR_W-1:0]  threshold
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (wr_en && (paddr[2] == REG_THRESHOLD)) begin
      threshold <= pwdata[THR_W-1:0];
    end
  end

  // read back, low two address bits are the byte offset
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_THRESHOLD) begin
      prdata = DATA_W'(threshold);
    end
  end

endmodule

`default_nettype wire

FILE: sv/ctss_slot_file.sv
// slot storage: enable and free flags, deadlines and tags, one read port
`default_nettype none

module ctss_slot_file
  import ctss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire slot_cmd_t   cmd,
  input  wire idx_t        rd_idx,
  output slot_entry_t      rd_entry,
  output free_info_t       free_info
);

  logic [SLOT_COUNT-1:0] enabled;
  logic [SLOT_COUNT-1:0] free;
  logic [15:0]           deadline [SLOT_COUNT];
  logic [7:0]            tag      [SLOT_COUNT];

  // flag updates
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
      free    <= '1;
    end else begin
      if (cmd.sched) begin
        enabled[cmd.sched_idx] <= 1'b1;
        free[cmd.sched_idx]    <= 1'b0;
      end
      if (cmd.dis) begin
        enabled[cmd.dis_idx] <= 1'b0;
      end
      if (cmd.rel) begin
        free[cmd.rel_idx] <= 1'b1;
      end
    end
  end

  // deadline and tag store
  always_ff @(posedge clk) begin
    if (cmd.sched) begin
      deadline[cmd.sched_idx] <= cmd.deadline;
      tag[cmd.sched_idx]      <= cmd.tag;
    end
  end

  // read port
  always_comb begin
    rd_entry.enabled  = enabled[rd_idx];
    rd_entry.deadline = deadline[rd_idx];
    rd_entry.tag      = tag[rd_idx];
  end

  // lowest free slot
  always_comb begin
    free_info.any_free   = |free;
    free_info.first_free = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free[i]) begin
        free_info.first_free = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/ctss_dist_unit.sv
// wrapped distance to a deadline and due-window check
`default_nettype none

module ctss_dist_unit
  import ctss_pkg::*;
(
  input  wire logic [15:0]      deadline,
  input  wire logic [15:0]      now,
  input  wire logic [THR_W-1:0] threshold,
  output logic      [15:0]      gap,
  output logic                  due
);

  logic [16:0] upper;

  // distance modulo the timer width
  assign gap   = deadline - now;
  assign upper = 17'h10000 - 17'(threshold);

  // due when just ahead of or just past now
  assign due = (17'(gap) < 17'(threshold)) || (17'(gap) > upper);

endmodule

`default_nettype wire

FILE: sv/compare_timer_slot_scheduler.sv
// top level: request sequencer, slot scan and result word register
`default_nettype none

// Shares one 16-bit compare timer among SLOT_COUNT deadline slots. A schedule
// (operation 0) takes the lowest free slot and rescans; a compare match
// (operation 1) rescans. A rescan walks the slots one per cycle through a
// single distance unit; it pauses on a due slot while the output register
// still holds a word the result side has not taken. A release (operation 2)
// of an existing slot, or a schedule with no free slot, gives one word; a
// release of a slot past the table gives none. Ready is low while an item is
// in work. Each rescan yields one fired word per enabled due slot in slot
// order, then one compare word with last set. The due threshold sits at byte
// address 0 of the configuration port (reset 30).

module compare_timer_slot_scheduler
  import ctss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  ctss_in_if.sink                in_ch,
  ctss_out_if.source             out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_REL,
    S_ERR
  } state_t;

  state_t           state;
  idx_t             idx;
  idx_t             rel_idx;
  logic [15:0]      now_q;
  logic [15:0]      next_dist;
  logic [THR_W-1:0] threshold;

  logic             out_valid;
  logic [1:0]       out_kind;
  logic [2:0]       out_slot;
  logic [7:0]       out_tag;
  logic [15:0]      out_deadline;
  logic [15:0]      out_compare;
  logic             out_last;

  slot_cmd_t        cmd;
  idx_t             rd_idx;
  slot_entry_t      entry;
  free_info_t       free_info;
  logic [15:0]      gap;
  logic             due;
  logic             accept;
  logic             can_emit;
  logic             fire;
  logic             scan_done;

  ctss_apb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .threshold (threshold)
  );

  ctss_slot_file u_slots (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .rd_entry  (entry),
    .free_info (free_info)
  );

  ctss_dist_unit u_dist (
    .deadline  (entry.deadline),
    .now       (now_q),
    .threshold (threshold),
    .gap       (gap),
    .due       (due)
  );

  // handshake and scan status
  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign can_emit    = !out_valid || out_ch.ready;
  assign fire        = (state == S_SCAN) && entry.enabled && due;
  assign scan_done   = (idx == IDX_W'(SLOT_COUNT - 1));
  assign rd_idx      = (state == S_REL) ? rel_idx : idx;

  // slot file writes
  always_comb begin
    cmd.sched     = accept && (in_ch.operation == OP_SCHEDULE) && free_info.any_free;
    cmd.sched_idx = free_info.first_free;
    cmd.deadline  = in_ch.deadline;
    cmd.tag       = in_ch.tag;
    cmd.rel       = (state == S_REL) && can_emit;
    cmd.rel_idx   = rel_idx;
    cmd.dis       = fire && can_emit;
    cmd.dis_idx   = idx;
  end

  // sequencer and result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            now_q     <= in_ch.now;
            idx       <= '0;
            next_dist <= DIST_NONE;
            rel_idx   <= slot_index(in_ch.slot);
            case (in_ch.operation)
              OP_SCHEDULE: state <= free_info.any_free ? S_SCAN : S_ERR;
              OP_RESCAN:   state <= S_SCAN;
              OP_RELEASE:  state <= slot_in_range(in_ch.slot) ? S_REL : S_IDLE;
              default:     state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (!fire || can_emit) begin
            if (fire) begin
              out_valid    <= 1'b1;
              out_kind     <= KIND_FIRED;
              out_slot     <= slot_field(idx);
              out_tag      <= '0;
              out_deadline <= '0;
              out_compare  <= '0;
              out_last     <= 1'b0;
            end else if (entry.enabled && (gap < next_dist)) begin
              next_dist <= gap;
            end
            if (scan_done) begin
              state <= S_CMP;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_CMP: begin
          if (can_emit) begin
            out_valid    <= 1'b1;
            out_kind     <= KIND_COMPARE;
            out_slot     <= '0;
            out_tag      <= '0;
            out_deadline <= '0;
            out_compare  <= now_q + next_dist;
            out_last     <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_REL: begin
          if (can_emit) begin
            out_valid    <= 1'b1;
            out_kind     <= KIND_RELEASED;
            out_slot     <= slot_field(rel_idx);
            out_tag      <= entry.tag;
            out_deadline <= entry.deadline;
            out_compare  <= '0;
            out_last     <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_ERR: begin
          if (can_emit) begin
            out_valid    <= 1'b1;
            out_kind     <= KIND_NO_SLOT;
            out_slot     <= '0;
            out_tag      <= '0;
            out_deadline <= '0;
            out_compare  <= '0;
            out_last     <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result channel
  assign out_ch.valid           = out_valid;
  assign out_ch.kind            = out_kind;
  assign out_ch.result_slot     = out_slot;
  assign out_ch.result_tag      = out_tag;
  assign out_ch.result_deadline = out_deadline;
  assign out_ch.compare_value   = out_compare;
  assign out_ch.last            = out_last;

  // smallest distance only shrinks during a scan
  a_next_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> (next_dist <= $past(next_dist)))
    else $error("next distance grew during scan");

  // a compare word always closes its item
  a_compare_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.kind == KIND_COMPARE)) |-> out_ch.last)
    else $error("compare word without last");

  // fired words name an existing slot and never close the item
  a_fired_slot: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.kind == KIND_FIRED)) |->
      ((6'(out_ch.result_slot) < 6'(SLOT_COUNT)) && !out_ch.last))
    else $error("bad fired word");

  // a disable only happens while its word is taken into the output register
  a_disable_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.dis |=> (out_valid && (out_kind == KIND_FIRED)))
    else $error("slot disabled without fired word");

endmodule

`default_nettype wire

FILE: test/ctss_checker.sv
// scoreboard for the slot scheduler: tracks slot state, predicts result words, compares
`default_nettype none

module ctss_checker
  import ctss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  input  wire logic [DATA_W-1:0] prdata,
  input  wire logic              pready,
  ctss_in_if                     in_mon,
  ctss_out_if                    out_mon,
  output int                     fails,
  output int                     owed,
  output int                     words_seen,
  output int                     fired_seen,
  output int                     refusals
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = ADDR_W'(4 * REG_THRESHOLD);

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  result_slot;
    logic [7:0]  result_tag;
    logic [15:0] result_deadline;
    logic [15:0] compare_value;
    logic        last;
  } slot_report_t;

  // mirror of the slot file and the due window
  int          gate;
  logic        slot_armed [SLOT_COUNT];
  logic        slot_open  [SLOT_COUNT];
  logic [15:0] slot_due   [SLOT_COUNT];
  logic [7:0]  slot_code  [SLOT_COUNT];

  slot_report_t reports_owed [$];

  task automatic push_report(input logic [1:0] kind, input logic [2:0] sl,
                             input logic [7:0] code, input logic [15:0] due,
                             input logic [15:0] cmp, input logic fin);
    slot_report_t r;
    r.kind            = kind;
    r.result_slot     = sl;
    r.result_tag      = code;
    r.result_deadline = due;
    r.compare_value   = cmp;
    r.last            = fin;
    reports_owed.push_back(r);
  endtask

  // fire every armed slot inside the window, then report the compare value at the nearest remaining distance
  task automatic rescan_slots(input logic [15:0] now);
    int          i;
    int          distance;
    int          nearest;
    logic [15:0] gap;
    nearest = int'(DIST_NONE);
    for (i = 0; i < SLOT_COUNT; i++) begin
      if (slot_armed[i]) begin
        gap      = slot_due[i] - now;
        distance = int'(gap);
        if (distance < gate || distance > 65536 - gate) begin
          push_report(KIND_FIRED, 3'(i), 8'h0, 16'h0, 16'h0, 1'b0);
          slot_armed[i] = 1'b0;
        end else if (distance < nearest) begin
          nearest = distance;
        end
      end
    end
    gap = now + 16'(nearest);
    push_report(KIND_COMPARE, 3'h0, 8'h0, 16'h0, gap, 1'b1);
  endtask

  // work out the result words of one accepted request
  task automatic take_request(input logic [1:0] op, input logic [15:0] now,
                              input logic [15:0] due, input logic [7:0] code,
                              input logic [2:0] sl);
    int i;
    int pick;
    pick = -1;
    case (op)
      OP_SCHEDULE: begin
        for (i = SLOT_COUNT - 1; i >= 0; i--) begin
          if (slot_open[i]) pick = i;
        end
        if (pick < 0) begin
          push_report(KIND_NO_SLOT, 3'h0, 8'h0, 16'h0, 16'h0, 1'b1);
        end else begin
          slot_open[pick]  = 1'b0;
          slot_due[pick]   = due;
          slot_code[pick]  = code;
          slot_armed[pick] = 1'b1;
          rescan_slots(now);
        end
      end
      OP_RESCAN: begin
        rescan_slots(now);
      end
      OP_RELEASE: begin
        // a released slot keeps its armed bit
        if (int'(sl) < SLOT_COUNT) begin
          push_report(KIND_RELEASED, sl, slot_code[sl], slot_due[sl], 16'h0, 1'b1);
          slot_open[sl] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    int           k;
    slot_report_t want;
    if (rst) begin
      gate = int'(THR_RESET);
      for (k = 0; k < SLOT_COUNT; k++) begin
        slot_armed[k] = 1'b0;
        slot_open[k]  = 1'b1;
        slot_due[k]   = 16'h0;
        slot_code[k]  = 8'h0;
      end
      reports_owed.delete();
    end else begin
      // register port: track writes, check read-back
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == THRESHOLD_ADDR) gate = int'(pwdata[THR_W-1:0]);
        end else begin
          check_field("prdata", 32'(gate), 32'(prdata));
        end
      end
      // result word against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        words_seen++;
        if (reports_owed.size() == 0) begin
          $error("result word kind %0d with nothing expected", out_mon.kind);
          fails++;
        end else begin
          want = reports_owed.pop_front();
          if (want.kind == KIND_FIRED) fired_seen++;
          if (want.kind == KIND_NO_SLOT) refusals++;
          check_field("kind", 32'(want.kind), 32'(out_mon.kind));
          check_field("result_slot", 32'(want.result_slot), 32'(out_mon.result_slot));
          check_field("result_tag", 32'(want.result_tag), 32'(out_mon.result_tag));
          check_field("result_deadline", 32'(want.result_deadline),
                      32'(out_mon.result_deadline));
          check_field("compare_value", 32'(want.compare_value),
                      32'(out_mon.compare_value));
          check_field("last", 32'(want.last), 32'(out_mon.last));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        take_request(in_mon.operation, in_mon.now, in_mon.deadline, in_mon.tag,
                     in_mon.slot);
      end
    end
    owed = reports_owed.size();
  end

endmodule

`default_nettype wire

FILE: test/tb.sv
// testbench top: clock, reset, request and register stimulus, result back-pressure, verdict
`default_nettype none

module tb;
  import ctss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]        OP_UNUSED      = 2'd3;
  localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = ADDR_W'(4 * REG_THRESHOLD);
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 48;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ctss_in_if  req_ch ();
  ctss_out_if rsp_ch ();

  int fails;
  int owed;
  int words_seen;
  int fired_seen;
  int refusals;

  // stimulus bookkeeping
  int          cycles;
  int          requests;
  int          settings;
  int          gate_now;
  int          burst_left;
  bit          steady;
  logic        squeeze;
  logic [15:0] clock_now;
  logic [15:0] recent_due [6];
  int          recent_at;

  compare_timer_slot_scheduler u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (req_ch),
    .out_ch  (rsp_ch)
  );

  ctss_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_mon     (req_ch),
    .out_mon    (rsp_ch),
    .fails      (fails),
    .owed       (owed),
    .words_seen (words_seen),
    .fired_seen (fired_seen),
    .refusals   (refusals)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, owed);
      $display("tb NOT OK");
      $finish;
    end
  end

  // result side: random ready segments, one long hold once asked
  initial begin : receiver
    int mode;
    int span;
    int i;
    bit held;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (squeeze && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (i = 0; i < span; i++) begin
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
          2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // hold one request word until accepted, then maybe end the burst
  task automatic offer(input logic [1:0] op, input logic [15:0] now,
                       input logic [15:0] due, input logic [7:0] code,
                       input logic [2:0] sl);
    int gap;
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.now       <= now;
    req_ch.deadline  <= due;
    req_ch.tag       <= code;
    req_ch.slot      <= sl;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    if (op != OP_UNUSED && !(op == OP_RELEASE && int'(sl) >= SLOT_COUNT)) requests++;
    if (!steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 8);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          req_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  endtask

  // wait for every expected word, then let a no-result item finish
  task automatic settle();
    if (req_ch.valid) req_ch.valid <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write the due window, then read it back
  task automatic set_gate(input int value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= THRESHOLD_ADDR;
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    gate_now = value;
    settings++;
  endtask

  // mostly timer-like traffic around recent deadlines, some noise
  task automatic random_request();
    int          pick;
    int          jitter;
    logic [15:0] due;
    logic [2:0]  sl;
    pick      = $urandom_range(0, 99);
    jitter    = $urandom_range(0, 2 * gate_now + 8) - (gate_now + 4);
    clock_now = clock_now + 16'($urandom_range(0, 400));
    if (pick < 6) begin
      offer(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 8'($urandom),
            3'($urandom_range(0, 7)));
    end else if (pick < 40) begin
      case ($urandom_range(0, 2))
        0:       due = clock_now + 16'(jitter);
        1:       due = clock_now + 16'($urandom_range(0, 4000));
        default: due = 16'($urandom);
      endcase
      recent_due[recent_at] = due;
      recent_at = (recent_at + 1) % 6;
      offer(OP_SCHEDULE, clock_now, due, 8'($urandom), 3'($urandom_range(0, 7)));
    end else if (pick < 70) begin
      if ($urandom_range(0, 2) != 0) begin
        clock_now = recent_due[$urandom_range(0, 5)] + 16'(jitter);
      end
      offer(OP_RESCAN, clock_now, 16'($urandom), 8'($urandom), 3'($urandom_range(0, 7)));
    end else begin
      sl = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      offer(OP_RELEASE, clock_now, 16'($urandom), 8'($urandom), sl);
    end
  endtask

  initial begin : stimulus
    int phase;
    int quota;
    int k;
    int gates [6];
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_SCHEDULE;
    req_ch.now       = 16'h0;
    req_ch.deadline  = 16'h0;
    req_ch.tag       = 8'h0;
    req_ch.slot      = 3'h0;
    squeeze          = 1'b0;
    steady           = 1'b0;
    burst_left       = 1;
    requests         = 0;
    settings         = 0;
    gate_now         = 30;
    recent_at        = 0;
    clock_now        = 16'h0;
    foreach (recent_due[k]) recent_due[k] = 16'h0;
    gates = '{30, 0, 32767, 1, 0, 500};
    gates[4] = $urandom_range(2, 32766);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_gate(30);

    // fill all six slots: far, exactly due, just inside, window edge, edge, just inside
    offer(OP_SCHEDULE, 16'h0000, 16'd100, 8'h00, 3'd0);
    offer(OP_SCHEDULE, 16'hffff, 16'hffff, 8'hff, 3'd7);
    offer(OP_SCHEDULE, 16'd1000, 16'd1029, 8'h5a, 3'd0);
    offer(OP_SCHEDULE, 16'd1000, 16'd1030, 8'ha5, 3'd0);
    offer(OP_SCHEDULE, 16'd2000, 16'd1970, 8'h3c, 3'd0);
    offer(OP_SCHEDULE, 16'd2000, 16'd1971, 8'hc3, 3'd0);
    // table full
    offer(OP_SCHEDULE, 16'd2100, 16'd3000, 8'h77, 3'd0);
    // ignored: slots past the table, unused operation
    offer(OP_RELEASE, 16'd2100, 16'h0, 8'h0, 3'd6);
    offer(OP_RELEASE, 16'd2100, 16'h0, 8'h0, 3'd7);
    offer(OP_UNUSED, 16'hffff, 16'hffff, 8'hff, 3'd7);
    // release a still-armed slot twice, then let it fire
    offer(OP_RELEASE, 16'd2100, 16'h0, 8'h0, 3'd3);
    offer(OP_RELEASE, 16'd2100, 16'h0, 8'h0, 3'd3);
    offer(OP_RESCAN, 16'd1030, 16'h0, 8'h0, 3'd0);
    offer(OP_RELEASE, 16'd1100, 16'h0, 8'h0, 3'd0);
    offer(OP_RELEASE, 16'd1100, 16'h0, 8'h0, 3'd1);
    offer(OP_RELEASE, 16'd1100, 16'h0, 8'h0, 3'd2);
    offer(OP_RELEASE, 16'd1100, 16'h0, 8'h0, 3'd4);
    offer(OP_RELEASE, 16'd1100, 16'h0, 8'h0, 3'd5);
    // six close deadlines, then one rescan fires them all
    for (k = 0; k < SLOT_COUNT; k++) begin
      offer(OP_SCHEDULE, 16'h0000, 16'(5000 + 3 * k), 8'(k * 37), 3'd0);
    end
    offer(OP_RESCAN, 16'd5007, 16'h0, 8'h0, 3'd0);
    settle();

    clock_now = 16'($urandom);
    for (phase = 0; phase < 6; phase++) begin
      set_gate(gates[phase]);
      steady = (phase == 1);
      if (phase == 1) squeeze = 1'b1;
      quota = requests + PHASE_ITEMS;
      while (requests < quota) random_request();
      settle();
    end

    $display("requests: %0d under %0d due-window settings, extremes included",
             requests, settings);
    $display("result words: %0d, slot firings: %0d, full-table refusals: %0d",
             words_seen, fired_seen, refusals);
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
sv/ctss_pkg.sv
sv/ctss_if.sv
sv/ctss_apb_regs.sv
sv/ctss_slot_file.sv
sv/ctss_dist_unit.sv
sv/compare_timer_slot_scheduler.sv
test/ctss_checker.sv
test/tb.sv
